[rtl/lgpc_pkg.sv]
`default_nettype none

package lgpc_pkg;

    // Input and output field widths.
    localparam int SUM_WIDTH     = 32;
    localparam int POINT_W       = 8;
    localparam int DB_W          = 16;
    localparam int DEG_W         = 15;
    localparam int MASK_W        = 3;

    // Iteration count of the log and CORDIC chains.
    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_CAP     = 24;
    localparam int NSTG          = (CORDIC_STAGES < STAGE_CAP) ? CORDIC_STAGES : STAGE_CAP;
    localparam int LOG_FRAC      = 24;

    // Datapath widths.
    localparam int EW   = SUM_WIDTH + 1;            // sums and error term
    localparam int PRW  = 2 * EW;                   // one product
    localparam int PW   = 2 * SUM_WIDTH + 4;        // Q, I and A, signed
    localparam int AW   = PW - 1;                   // magnitudes
    localparam int LW   = $clog2(AW + 1);           // bit length of a magnitude
    localparam int XW   = 30;                       // normalized Q and I
    localparam int SQW  = 2 * XW;
    localparam int NWW  = SQW + 1;                  // Q*Q + I*I after normalization
    localparam int NLW  = $clog2(NWW + 1);
    localparam int MW   = 32;                       // log mantissa
    localparam int CW   = XW + 4;                   // CORDIC x and y
    localparam int ZW   = 26;                       // CORDIC angle, 2^-16 degree
    localparam int DW   = $clog2(NWW + 4 * AW + 1) + LOG_FRAC + 1;
    localparam int CFW  = 26;                       // dB coefficient
    localparam int PDW  = DW + CFW;
    localparam int DB_RND_SH  = 40;
    localparam int DEG_RND_SH = 10;

    localparam logic signed [CFW-1:0] DB_COEF      = 26'sd12626113;
    localparam logic signed [ZW-1:0]  QUARTER_TURN = 26'sd5898240;
    localparam logic signed [ZW-1:0]  DEG_RND      = 26'sd512;
    localparam int DB_MAX  = 32767;
    localparam int DB_MIN  = -32768;
    localparam int DEG_MAX = 11520;
    localparam logic signed [DEG_W-1:0] DEG_HI = 15'sd11520;
    localparam logic signed [DEG_W-1:0] DEG_LO = -15'sd11520;

    // Ratio order, shared by the masks.
    localparam int RATIO_N = 3;
    localparam int RAT_GH  = 0;
    localparam int RAT_H   = 1;
    localparam int RAT_CL  = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_OPEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_PLANT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_CLOSED = 2'd2;

    // Pipeline depth.
    localparam int FRONT_STG = 3;
    localparam int RATIO_STG = 10 + NSTG;
    localparam int PIPE_LAT  = FRONT_STG + RATIO_STG;

    typedef struct packed {
        logic signed [PW-1:0] q;
        logic signed [PW-1:0] i;
        logic signed [PW-1:0] a;
    } t_qia;

    typedef struct packed {
        logic signed [DB_W-1:0]  db;
        logic signed [DEG_W-1:0] deg;
        logic                    zero;
    } t_ratio_res;

    // Arctangent of 2^-k in 2^-16 degree.
    function automatic logic signed [ZW-1:0] atan_deg16(input int k);
        case (k)
            0:       return ZW'(2949120);
            1:       return ZW'(1740967);
            2:       return ZW'(919879);
            3:       return ZW'(466945);
            4:       return ZW'(234379);
            5:       return ZW'(117304);
            6:       return ZW'(58666);
            7:       return ZW'(29335);
            8:       return ZW'(14668);
            9:       return ZW'(7334);
            10:      return ZW'(3667);
            11:      return ZW'(1833);
            12:      return ZW'(917);
            13:      return ZW'(458);
            14:      return ZW'(229);
            15:      return ZW'(115);
            16:      return ZW'(57);
            17:      return ZW'(29);
            18:      return ZW'(14);
            19:      return ZW'(7);
            20:      return ZW'(4);
            21:      return ZW'(2);
            22:      return ZW'(1);
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/lgpc_if.sv]
`default_nettype none

interface lgpc_in_if;
    import lgpc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [POINT_W-1:0]          point_index;
    logic signed [SUM_WIDTH-1:0] ref_sine_sum;
    logic signed [SUM_WIDTH-1:0] fb_sine_sum;
    logic signed [SUM_WIDTH-1:0] fb_cosine_sum;
    logic signed [SUM_WIDTH-1:0] drive_sine_sum;
    logic signed [SUM_WIDTH-1:0] drive_cosine_sum;

    modport source (
        output valid, point_index, ref_sine_sum, fb_sine_sum, fb_cosine_sum,
               drive_sine_sum, drive_cosine_sum,
        input  ready
    );
    modport sink (
        input  valid, point_index, ref_sine_sum, fb_sine_sum, fb_cosine_sum,
               drive_sine_sum, drive_cosine_sum,
        output ready
    );
endinterface

interface lgpc_out_if;
    import lgpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [POINT_W-1:0]      point_out;
    logic signed [DB_W-1:0]  open_loop_db;
    logic signed [DEG_W-1:0] open_loop_deg;
    logic signed [DB_W-1:0]  plant_db;
    logic signed [DEG_W-1:0] plant_deg;
    logic signed [DB_W-1:0]  closed_loop_db;
    logic signed [DEG_W-1:0] closed_loop_deg;
    logic [MASK_W-1:0]       computed_mask;
    logic [MASK_W-1:0]       zero_divisor_mask;

    modport source (
        output valid, point_out, open_loop_db, open_loop_deg, plant_db, plant_deg,
               closed_loop_db, closed_loop_deg, computed_mask, zero_divisor_mask,
        input  ready
    );
    modport sink (
        input  valid, point_out, open_loop_db, open_loop_deg, plant_db, plant_deg,
               closed_loop_db, closed_loop_deg, computed_mask, zero_divisor_mask,
        output ready
    );
endinterface

`default_nettype wire

[rtl/lgpc_front.sv]
`default_nettype none

module lgpc_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_adv,
    input  wire logic signed [lgpc_pkg::SUM_WIDTH-1:0] i_r,
    input  wire logic signed [lgpc_pkg::SUM_WIDTH-1:0] i_ys,
    input  wire logic signed [lgpc_pkg::SUM_WIDTH-1:0] i_yc,
    input  wire logic signed [lgpc_pkg::SUM_WIDTH-1:0] i_us,
    input  wire logic signed [lgpc_pkg::SUM_WIDTH-1:0] i_uc,
    output lgpc_pkg::t_qia                             o_qia [lgpc_pkg::RATIO_N]
);
    import lgpc_pkg::*;

    // First stage: widened sums and the error term.
    logic signed [EW-1:0] r_r, r_ys, r_yc, r_us, r_uc, r_e;

    // Second stage: all products.
    logic signed [PRW-1:0] r_ycys, r_yce, r_yse, r_ycyc, r_ee;
    logic signed [PRW-1:0] r_usyc, r_ucys, r_ysus, r_ucyc, r_ucuc, r_usus;
    logic signed [PRW-1:0] r_ycr, r_ysr, r_rr;

    // Third stage: Q, I and A of each ratio.
    t_qia r_qia [RATIO_N];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_r  <= EW'(i_r);
            r_ys <= EW'(i_ys);
            r_yc <= EW'(i_yc);
            r_us <= EW'(i_us);
            r_uc <= EW'(i_uc);
            r_e  <= EW'(i_ys) - EW'(i_r);

            r_ycys <= PRW'(r_yc) * PRW'(r_ys);
            r_yce  <= PRW'(r_yc) * PRW'(r_e);
            r_yse  <= PRW'(r_ys) * PRW'(r_e);
            r_ycyc <= PRW'(r_yc) * PRW'(r_yc);
            r_ee   <= PRW'(r_e)  * PRW'(r_e);
            r_usyc <= PRW'(r_us) * PRW'(r_yc);
            r_ucys <= PRW'(r_uc) * PRW'(r_ys);
            r_ysus <= PRW'(r_ys) * PRW'(r_us);
            r_ucyc <= PRW'(r_uc) * PRW'(r_yc);
            r_ucuc <= PRW'(r_uc) * PRW'(r_uc);
            r_usus <= PRW'(r_us) * PRW'(r_us);
            r_ycr  <= PRW'(r_yc) * PRW'(r_r);
            r_ysr  <= PRW'(r_ys) * PRW'(r_r);
            r_rr   <= PRW'(r_r)  * PRW'(r_r);

            r_qia[RAT_GH].q <= PW'(r_ycys) + PW'(r_yce);
            r_qia[RAT_GH].i <= PW'(r_yse) - PW'(r_ycyc);
            r_qia[RAT_GH].a <= PW'(r_ycyc) + PW'(r_ee);
            r_qia[RAT_H].q  <= PW'(r_usyc) - PW'(r_ucys);
            r_qia[RAT_H].i  <= PW'(r_ysus) + PW'(r_ucyc);
            r_qia[RAT_H].a  <= PW'(r_ucuc) + PW'(r_usus);
            r_qia[RAT_CL].q <= PW'(r_ycr);
            r_qia[RAT_CL].i <= PW'(r_ysr);
            r_qia[RAT_CL].a <= PW'(r_rr);
        end
    end

    assign o_qia = r_qia;

endmodule

`default_nettype wire

[rtl/lgpc_ratio.sv]
`default_nettype none

module lgpc_ratio (
    input  wire logic           i_clk,
    input  wire logic           i_adv,
    input  lgpc_pkg::t_qia      i_qia,
    output lgpc_pkg::t_ratio_res o_res
);
    import lgpc_pkg::*;

    // Signs and special-case flags that ride along the whole pipe.
    typedef struct packed {
        logic qneg;
        logic ineg;
        logic az;
        logic mz;
    } t_rcar;

    function automatic logic [LW-1:0] blen_a(input logic [AW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int j = 0; j < AW; j++) begin
            if (v[j]) n = LW'(j + 1);
        end
        return n;
    endfunction

    function automatic logic [NLW-1:0] blen_n(input logic [NWW-1:0] v);
        logic [NLW-1:0] n;
        n = '0;
        for (int j = 0; j < NWW; j++) begin
            if (v[j]) n = NLW'(j + 1);
        end
        return n;
    endfunction

    // Stage 1: magnitudes.
    logic [AW-1:0] r1_aq, r1_ai, r1_a;
    t_rcar         r1_c;
    // Stage 2: bit lengths.
    logic [AW-1:0] r2_aq, r2_ai, r2_a;
    logic [LW-1:0] r2_l, r2_la;
    t_rcar         r2_c;
    // Stage 3: normalization to 30 bits, mantissa of A.
    logic [XW-1:0]        r3_xq, r3_xi;
    logic signed [LW:0]   r3_sh;
    logic [MW-1:0]        r3_ma;
    logic [LW-1:0]        r3_pa;
    t_rcar                r3_c;
    // Stage 4: squares.
    logic [SQW-1:0]       r4_sq, r4_si;
    logic [XW-1:0]        r4_xq, r4_xi;
    logic signed [LW:0]   r4_sh;
    logic [MW-1:0]        r4_ma;
    logic [LW-1:0]        r4_pa;
    t_rcar                r4_c;
    // Stage 5: sum of squares.
    logic [NWW-1:0]       r5_nw;
    logic [XW-1:0]        r5_xq, r5_xi;
    logic signed [LW:0]   r5_sh;
    logic [MW-1:0]        r5_ma;
    logic [LW-1:0]        r5_pa;
    t_rcar                r5_c;
    // Stage 6: bit length of the sum.
    logic [NWW-1:0]       r6_nw;
    logic [NLW-1:0]       r6_ln;
    logic [XW-1:0]        r6_xq, r6_xi;
    logic signed [LW:0]   r6_sh;
    logic [MW-1:0]        r6_ma;
    logic [LW-1:0]        r6_pa;
    t_rcar                r6_c;

    // Iteration chain; entry 0 is written by stage 7.
    logic [MW-1:0]        r_mn [NSTG+1];
    logic [MW-1:0]        r_ma [NSTG+1];
    logic [NSTG-1:0]      r_fn [NSTG+1];
    logic [NSTG-1:0]      r_fa [NSTG+1];
    logic signed [CW-1:0] r_x  [NSTG+1];
    logic signed [CW-1:0] r_y  [NSTG+1];
    logic signed [ZW-1:0] r_z  [NSTG+1];
    logic [NLW-1:0]       r_pn [NSTG+1];
    logic [LW-1:0]        r_pa [NSTG+1];
    logic signed [LW:0]   r_sh [NSTG+1];
    t_rcar                r_c  [NSTG+1];

    // Final stages.
    logic signed [DW-1:0]    rd_d;
    logic signed [DEG_W-1:0] rd_deg;
    t_rcar                   rd_c;
    logic signed [PDW-1:0]   rm_p;
    logic signed [DEG_W-1:0] rm_deg;
    t_rcar                   rm_c;
    t_ratio_res              r_res;

    // Next values.
    logic [AW-1:0]        n1_aq, n1_ai;
    logic [XW-1:0]        n3_xq, n3_xi;
    logic signed [LW:0]   n3_sh;
    logic [MW-1:0]        n3_ma;
    logic [MW-1:0]        n7_mn;
    logic signed [CW-1:0] n7_x, n7_y, n7_xv, n7_yv;
    logic signed [ZW-1:0] n7_z;
    logic [MW-1:0]        n_mn [NSTG];
    logic [MW-1:0]        n_ma [NSTG];
    logic [NSTG-1:0]      n_fn [NSTG];
    logic [NSTG-1:0]      n_fa [NSTG];
    logic signed [CW-1:0] n_x  [NSTG];
    logic signed [CW-1:0] n_y  [NSTG];
    logic signed [ZW-1:0] n_z  [NSTG];
    logic [2*MW-1:0]      n_sqn, n_sqa;
    logic signed [DW-1:0] n_ln2, n_la2, n_d;
    logic signed [ZW-1:0] n_zr;
    logic signed [DEG_W-1:0] n_deg;
    logic signed [PDW-1:0]   n_sum, n_v, c_rnd;
    logic signed [DB_W-1:0]  n_db;

    assign c_rnd = $signed(PDW'(1) << (DB_RND_SH - 1));

    always_comb begin
        // Stage 1 and 3.
        n1_aq = i_qia.q[PW-1] ? AW'(-i_qia.q) : AW'(i_qia.q);
        n1_ai = i_qia.i[PW-1] ? AW'(-i_qia.i) : AW'(i_qia.i);
        n3_sh = $signed({1'b0, r2_l}) - $signed((LW + 1)'(XW));
        if (r2_l > LW'(XW)) begin
            n3_xq = XW'(r2_aq >> (r2_l - LW'(XW)));
            n3_xi = XW'(r2_ai >> (r2_l - LW'(XW)));
        end else begin
            n3_xq = XW'(r2_aq << (LW'(XW) - r2_l));
            n3_xi = XW'(r2_ai << (LW'(XW) - r2_l));
        end
        if (r2_la > LW'(MW)) begin
            n3_ma = MW'(r2_a >> (r2_la - LW'(MW)));
        end else begin
            n3_ma = MW'(r2_a << (LW'(MW) - r2_la));
        end

        // Stage 7: mantissa of the sum, quarter-turn pre-rotation.
        if (r6_ln > NLW'(MW)) begin
            n7_mn = MW'(r6_nw >> (r6_ln - NLW'(MW)));
        end else begin
            n7_mn = MW'(r6_nw << (NLW'(MW) - r6_ln));
        end
        n7_yv = r6_c.qneg ? -$signed(CW'(r6_xq)) : $signed(CW'(r6_xq));
        n7_xv = r6_c.ineg ? -$signed(CW'(r6_xi)) : $signed(CW'(r6_xi));
        if (n7_xv < 0) begin
            if (n7_yv >= 0) begin
                n7_x = n7_yv;
                n7_y = -n7_xv;
                n7_z = QUARTER_TURN;
            end else begin
                n7_x = -n7_yv;
                n7_y = n7_xv;
                n7_z = -QUARTER_TURN;
            end
        end else begin
            n7_x = n7_xv;
            n7_y = n7_yv;
            n7_z = '0;
        end

        // Iterations: one squaring step of each log and one micro-rotation.
        for (int k = 0; k < NSTG; k++) begin
            n_sqn = ((2 * MW)'(r_mn[k]) * (2 * MW)'(r_mn[k])) >> (MW - 1);
            n_sqa = ((2 * MW)'(r_ma[k]) * (2 * MW)'(r_ma[k])) >> (MW - 1);
            n_fn[k] = r_fn[k];
            n_fa[k] = r_fa[k];
            if (n_sqn[MW]) begin
                n_mn[k] = n_sqn[MW:1];
                n_fn[k][NSTG-1-k] = 1'b1;
            end else begin
                n_mn[k] = n_sqn[MW-1:0];
            end
            if (n_sqa[MW]) begin
                n_ma[k] = n_sqa[MW:1];
                n_fa[k][NSTG-1-k] = 1'b1;
            end else begin
                n_ma[k] = n_sqa[MW-1:0];
            end
            if (r_y[k] > 0) begin
                n_x[k] = r_x[k] + (r_y[k] >>> k);
                n_y[k] = r_y[k] - (r_x[k] >>> k);
                n_z[k] = r_z[k] + atan_deg16(k);
            end else begin
                n_x[k] = r_x[k] - (r_y[k] >>> k);
                n_y[k] = r_y[k] + (r_x[k] >>> k);
                n_z[k] = r_z[k] - atan_deg16(k);
            end
        end

        // Log difference in 2^-24 units of log2, and the rounded angle.
        n_ln2 = $signed((DW'(r_pn[NSTG]) << LOG_FRAC) + (DW'(r_fn[NSTG]) << (LOG_FRAC - NSTG)));
        n_la2 = $signed((DW'(r_pa[NSTG]) << LOG_FRAC) + (DW'(r_fa[NSTG]) << (LOG_FRAC - NSTG)));
        n_d   = n_ln2 - (n_la2 <<< 1) + (DW'(r_sh[NSTG]) <<< (LOG_FRAC + 1));
        n_zr  = (r_z[NSTG] + DEG_RND) >>> DEG_RND_SH;
        if (n_zr > DEG_MAX) begin
            n_deg = DEG_HI;
        end else if (n_zr < -DEG_MAX) begin
            n_deg = DEG_LO;
        end else begin
            n_deg = DEG_W'(n_zr);
        end

        // Round to 1/64 dB and saturate.
        n_sum = rm_p + c_rnd;
        n_v   = n_sum >>> DB_RND_SH;
        if (n_v > DB_MAX) begin
            n_db = DB_W'(DB_MAX);
        end else if (n_v < DB_MIN) begin
            n_db = DB_W'(DB_MIN);
        end else begin
            n_db = DB_W'(n_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_aq     <= n1_aq;
            r1_ai     <= n1_ai;
            r1_a      <= AW'(i_qia.a);
            r1_c.qneg <= i_qia.q[PW-1];
            r1_c.ineg <= i_qia.i[PW-1];
            r1_c.az   <= (i_qia.a == '0);
            r1_c.mz   <= (i_qia.q == '0) && (i_qia.i == '0);

            r2_aq <= r1_aq;
            r2_ai <= r1_ai;
            r2_a  <= r1_a;
            r2_l  <= blen_a(r1_aq | r1_ai);
            r2_la <= blen_a(r1_a);
            r2_c  <= r1_c;

            r3_xq <= n3_xq;
            r3_xi <= n3_xi;
            r3_sh <= n3_sh;
            r3_ma <= n3_ma;
            r3_pa <= r2_la - LW'(1);
            r3_c  <= r2_c;

            r4_sq <= SQW'(r3_xq) * SQW'(r3_xq);
            r4_si <= SQW'(r3_xi) * SQW'(r3_xi);
            r4_xq <= r3_xq;
            r4_xi <= r3_xi;
            r4_sh <= r3_sh;
            r4_ma <= r3_ma;
            r4_pa <= r3_pa;
            r4_c  <= r3_c;

            r5_nw <= NWW'(r4_sq) + NWW'(r4_si);
            r5_xq <= r4_xq;
            r5_xi <= r4_xi;
            r5_sh <= r4_sh;
            r5_ma <= r4_ma;
            r5_pa <= r4_pa;
            r5_c  <= r4_c;

            r6_nw <= r5_nw;
            r6_ln <= blen_n(r5_nw);
            r6_xq <= r5_xq;
            r6_xi <= r5_xi;
            r6_sh <= r5_sh;
            r6_ma <= r5_ma;
            r6_pa <= r5_pa;
            r6_c  <= r5_c;

            r_mn[0] <= n7_mn;
            r_ma[0] <= r6_ma;
            r_fn[0] <= '0;
            r_fa[0] <= '0;
            r_x[0]  <= n7_x;
            r_y[0]  <= n7_y;
            r_z[0]  <= n7_z;
            r_pn[0] <= r6_ln - NLW'(1);
            r_pa[0] <= r6_pa;
            r_sh[0] <= r6_sh;
            r_c[0]  <= r6_c;

            for (int k = 0; k < NSTG; k++) begin
                r_mn[k+1] <= n_mn[k];
                r_ma[k+1] <= n_ma[k];
                r_fn[k+1] <= n_fn[k];
                r_fa[k+1] <= n_fa[k];
                r_x[k+1]  <= n_x[k];
                r_y[k+1]  <= n_y[k];
                r_z[k+1]  <= n_z[k];
                r_pn[k+1] <= r_pn[k];
                r_pa[k+1] <= r_pa[k];
                r_sh[k+1] <= r_sh[k];
                r_c[k+1]  <= r_c[k];
            end

            rd_d   <= n_d;
            rd_deg <= n_deg;
            rd_c   <= r_c[NSTG];

            rm_p   <= PDW'(rd_d) * PDW'(DB_COEF);
            rm_deg <= rd_deg;
            rm_c   <= rd_c;

            // A zero divisor wins over a zero magnitude.
            if (rm_c.az) begin
                r_res.db  <= '0;
                r_res.deg <= '0;
            end else if (rm_c.mz) begin
                r_res.db  <= DB_W'(DB_MIN);
                r_res.deg <= '0;
            end else begin
                r_res.db  <= n_db;
                r_res.deg <= rm_deg;
            end
            r_res.zero <= rm_c.az;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/loop_gain_phase_calculator_core.sv]
`default_nettype none

// The core takes one word per cycle unless a result waits untaken at the output; the depth
// is set by the log2 squaring and CORDIC chain, which runs one iteration per stage next to
// each other in each of the three ratio pipes.
// Reset clears every valid bit of the pipe and sets all three ratio enables.
// A stall on the output holds the whole pipe in place.
module loop_gain_phase_calculator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lgpc_in_if.sink                              i_item,
    lgpc_out_if.source                           o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [lgpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic                            i_cfg_data
);
    import lgpc_pkg::*;

    // Ratio enables.
    logic r_en_gh, r_en_h, r_en_cl;

    // Control that travels next to the datapath: valid bit, point number and
    // the enables seen when the word entered.
    logic [PIPE_LAT-1:0] r_vld;
    logic [POINT_W-1:0]  r_pt [PIPE_LAT];
    logic [MASK_W-1:0]   r_en [PIPE_LAT];

    logic       w_adv;
    t_qia       w_qia [RATIO_N];
    t_ratio_res w_res [RATIO_N];
    logic [MASK_W-1:0] w_en;
    logic [MASK_W-1:0] w_zero;

    // The pipe moves whenever the output register is empty or being taken,
    // so a new word can enter while a finished result is being taken.
    assign w_adv        = !r_vld[PIPE_LAT-1] || o_result.ready;
    assign i_item.ready = w_adv;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_gh <= 1'b1;
            r_en_h  <= 1'b1;
            r_en_cl <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EN_OPEN:   r_en_gh <= i_cfg_data;
                CFG_EN_PLANT:  r_en_h  <= i_cfg_data;
                CFG_EN_CLOSED: r_en_cl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pt[0] <= i_item.point_index;
            r_en[0] <= {r_en_cl, r_en_h, r_en_gh};
            for (int j = 1; j < PIPE_LAT; j++) begin
                r_pt[j] <= r_pt[j-1];
                r_en[j] <= r_en[j-1];
            end
        end
    end

    // Products and Q, I, A of the three ratios.
    lgpc_front u_front (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_r   (i_item.ref_sine_sum),
        .i_ys  (i_item.fb_sine_sum),
        .i_yc  (i_item.fb_cosine_sum),
        .i_us  (i_item.drive_sine_sum),
        .i_uc  (i_item.drive_cosine_sum),
        .o_qia (w_qia)
    );

    // One magnitude and phase pipe per ratio.
    for (genvar g = 0; g < RATIO_N; g++) begin : g_ratio
        lgpc_ratio u_ratio (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_qia (w_qia[g]),
            .o_res (w_res[g])
        );
    end

    // A disabled ratio reports zeros and clear mask bits.
    assign w_en   = r_en[PIPE_LAT-1];
    assign w_zero = {w_res[RAT_CL].zero, w_res[RAT_H].zero, w_res[RAT_GH].zero};

    assign o_result.valid             = r_vld[PIPE_LAT-1];
    assign o_result.point_out         = r_pt[PIPE_LAT-1];
    assign o_result.open_loop_db      = w_en[RAT_GH] ? w_res[RAT_GH].db  : '0;
    assign o_result.open_loop_deg     = w_en[RAT_GH] ? w_res[RAT_GH].deg : '0;
    assign o_result.plant_db          = w_en[RAT_H]  ? w_res[RAT_H].db   : '0;
    assign o_result.plant_deg         = w_en[RAT_H]  ? w_res[RAT_H].deg  : '0;
    assign o_result.closed_loop_db    = w_en[RAT_CL] ? w_res[RAT_CL].db  : '0;
    assign o_result.closed_loop_deg   = w_en[RAT_CL] ? w_res[RAT_CL].deg : '0;
    assign o_result.computed_mask     = w_en;
    assign o_result.zero_divisor_mask = w_en & w_zero;

    // A zero divisor is only ever flagged for a ratio that was computed.
    a_zero_in_computed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.zero_divisor_mask & ~o_result.computed_mask) == '0))
        else $error("zero divisor flagged for a ratio that was not computed");

    // The input is held back only while a result waits at the output.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> o_result.valid)
        else $error("input stalled with an empty output register");

    // A zero divisor forces the open-loop pair to zero.
    a_zero_forces_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.zero_divisor_mask[RAT_GH]) |->
        (o_result.open_loop_db == '0 && o_result.open_loop_deg == '0))
        else $error("open-loop pair not zero on a zero divisor");

    // The plant phase stays within half a turn.
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.plant_deg <= DEG_HI && o_result.plant_deg >= DEG_LO))
        else $error("plant phase out of range");

endmodule

`default_nettype wire

[dv/loop_gain_phase_checker.sv]
`default_nettype none

// Watches both channels and the enable write port. It predicts each result word
// from the accepted input word and the current ratio enables, then compares.
module loop_gain_phase_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lgpc_in_if        in_ch,
    lgpc_out_if       out_ch,
    input  wire logic i_cfg_we,
    input  wire logic [lgpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic i_cfg_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked
);
    import lgpc_pkg::*;

    typedef struct {
        logic [POINT_W-1:0]      point;
        logic signed [DB_W-1:0]  db  [RATIO_N];
        logic signed [DEG_W-1:0] deg [RATIO_N];
        logic [MASK_W-1:0]       done;
        logic [MASK_W-1:0]       zdiv;
    } t_expect;

    // Arctangent of 2^-k in 2^-16 degree.
    localparam longint ATAN_TAB [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic [RATIO_N-1:0] ratio_en;
    t_expect            expected_words [$];

    function automatic int bit_length(logic [127:0] v);
        for (int b = 127; b >= 0; b--)
            if (v[b]) return b + 1;
        return 0;
    endfunction

    // Log2 with 24 fraction bits by repeated squaring of a 1.31 mantissa.
    function automatic longint log2_fix(logic [127:0] v);
        int          p;
        logic [127:0] t;
        logic [63:0] m;
        longint      res;
        p = bit_length(v) - 1;
        if (p < 0) return 0;
        t = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
        m = {32'd0, t[31:0]};
        res = longint'(p) <<< 24;
        for (int k = 0; k < NSTG; k++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                res += 64'sd1 <<< (23 - k);
            end
        end
        return res;
    endfunction

    // Magnitude in 1/64 dB and phase in 1/64 degree of (I + jQ) / A.
    function automatic void gain_phase(input logic signed [127:0] q, input logic signed [127:0] i,
                                       input logic signed [127:0] a,
                                       output logic signed [DB_W-1:0] db,
                                       output logic signed [DEG_W-1:0] deg, output bit zero);
        logic [127:0] aq, ai;
        int           sh, lq, li;
        longint       xq, xi, x, y, z, t, d, v, xs, ys;
        logic [63:0]  nw;
        zero = 0;
        db   = '0;
        deg  = '0;
        if (a == 0) begin
            zero = 1;
            return;
        end
        aq = (q < 0) ? -q : q;
        ai = (i < 0) ? -i : i;
        if (aq == 0 && ai == 0) begin
            db = DB_W'(DB_MIN);
            return;
        end
        lq = bit_length(aq);
        li = bit_length(ai);
        sh = ((lq > li) ? lq : li) - 30;
        if (sh > 0) begin
            aq = aq >> sh;
            ai = ai >> sh;
        end else begin
            aq = aq << (-sh);
            ai = ai << (-sh);
        end
        xq = longint'(aq[63:0]);
        xi = longint'(ai[63:0]);
        nw = xq * xq + xi * xi;
        d = log2_fix({64'd0, nw}) + longint'(sh) * 2 * (64'sd1 <<< 24) - 2 * log2_fix(a);
        v = (d * longint'(DB_COEF) + (64'sd1 <<< 39)) >>> 40;
        if (v > DB_MAX) v = DB_MAX;
        if (v < DB_MIN) v = DB_MIN;
        db = v[DB_W-1:0];

        // Vectoring mode, with a quarter-turn first when the vector is in the left half.
        y = (q < 0) ? -xq : xq;
        x = (i < 0) ? -xi : xi;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 5898240;
            end else begin
                x = -y;
                y = t;
                z = -5898240;
            end
        end
        for (int k = 0; k < NSTG; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z += ATAN_TAB[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z -= ATAN_TAB[k];
            end
        end
        v = (z + 512) >>> 10;
        if (v > DEG_MAX) v = DEG_MAX;
        if (v < -DEG_MAX) v = -DEG_MAX;
        deg = v[DEG_W-1:0];
    endfunction

    function automatic t_expect predict_ratios(logic [POINT_W-1:0] point,
                                               logic signed [SUM_WIDTH-1:0] r_in,
                                               logic signed [SUM_WIDTH-1:0] ys_in,
                                               logic signed [SUM_WIDTH-1:0] yc_in,
                                               logic signed [SUM_WIDTH-1:0] us_in,
                                               logic signed [SUM_WIDTH-1:0] uc_in,
                                               logic [RATIO_N-1:0] en);
        t_expect w;
        logic signed [127:0] r, ys, yc, us, uc, e, q, i, a;
        bit z;
        r = r_in; ys = ys_in; yc = yc_in; us = us_in; uc = uc_in;
        e = ys - r;
        w.point = point;
        w.done  = '0;
        w.zdiv  = '0;
        for (int j = 0; j < RATIO_N; j++) begin
            w.db[j]  = '0;
            w.deg[j] = '0;
        end
        for (int j = 0; j < RATIO_N; j++) begin
            if (en[j]) begin
                if (j == RAT_GH) begin
                    q = yc * ys + yc * e;
                    i = ys * e - yc * yc;
                    a = yc * yc + e * e;
                end else if (j == RAT_H) begin
                    q = us * yc - uc * ys;
                    i = ys * us + uc * yc;
                    a = uc * uc + us * us;
                end else begin
                    q = yc * r;
                    i = ys * r;
                    a = r * r;
                end
                gain_phase(q, i, a, w.db[j], w.deg[j], z);
                w.done[j] = 1'b1;
                w.zdiv[j] = z;
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_expect want;
        if (!i_rst_n) begin
            ratio_en <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EN_OPEN:   ratio_en[RAT_GH] <= i_cfg_data;
                CFG_EN_PLANT:  ratio_en[RAT_H]  <= i_cfg_data;
                CFG_EN_CLOSED: ratio_en[RAT_CL] <= i_cfg_data;
                default:       ;
            endcase
        end

        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_words.push_back(predict_ratios(in_ch.point_index, in_ch.ref_sine_sum,
                                                    in_ch.fb_sine_sum, in_ch.fb_cosine_sum,
                                                    in_ch.drive_sine_sum,
                                                    in_ch.drive_cosine_sum, ratio_en));

        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word for point %0d arrived with none expected",
                         $time, out_ch.point_out);
                o_errors <= o_errors + 1;
            end else begin
                want = expected_words.pop_front();
                if (want.point !== out_ch.point_out
                    || want.db[RAT_GH] !== out_ch.open_loop_db
                    || want.deg[RAT_GH] !== out_ch.open_loop_deg
                    || want.db[RAT_H] !== out_ch.plant_db
                    || want.deg[RAT_H] !== out_ch.plant_deg
                    || want.db[RAT_CL] !== out_ch.closed_loop_db
                    || want.deg[RAT_CL] !== out_ch.closed_loop_deg
                    || want.done !== out_ch.computed_mask
                    || want.zdiv !== out_ch.zero_divisor_mask) begin
                    $display("%0t: mismatch expected pt=%0d gh=%0d/%0d h=%0d/%0d cl=%0d/%0d mask=%b zero=%b",
                             $time, want.point, want.db[RAT_GH], want.deg[RAT_GH],
                             want.db[RAT_H], want.deg[RAT_H], want.db[RAT_CL],
                             want.deg[RAT_CL], want.done, want.zdiv);
                    $display("%0t:          actual   pt=%0d gh=%0d/%0d h=%0d/%0d cl=%0d/%0d mask=%b zero=%b",
                             $time, out_ch.point_out, out_ch.open_loop_db, out_ch.open_loop_deg,
                             out_ch.plant_db, out_ch.plant_deg, out_ch.closed_loop_db,
                             out_ch.closed_loop_deg, out_ch.computed_mask,
                             out_ch.zero_divisor_mask);
                    o_errors <= o_errors + 1;
                end
                o_checked <= o_checked + 1;
            end
        end
        o_pending <= expected_words.size();
    end

    initial begin
        o_errors  = 0;
        o_checked = 0;
        o_pending = 0;
    end

endmodule

`default_nettype wire

[dv/loop_gain_phase_calculator_core_tb.sv]
`default_nettype none

// Top of the bench. It makes the clock, reset, input words, enable writes and
// the result-side backpressure. All checking lives in the checker instance.
module loop_gain_phase_calculator_core_tb;
    import lgpc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic i_cfg_data;

    int errors, pending, checked;
    int words_sent;
    int burst_left;
    bit long_hold_done;

    lgpc_in_if  in_ch ();
    lgpc_out_if out_ch ();

    loop_gain_phase_calculator_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    loop_gain_phase_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("Timeout with %0d result words still expected", pending);
        $display("TEST FAILED");
        $finish;
    end

    // The receiver runs on its own pattern: stretches of full acceptance,
    // random stalls, mostly-ready stretches, and one long hold-off while the
    // sender is busy so that the pipe fills and pushes back on the input.
    initial begin
        int cyc;
        int hold;
        int style;
        cyc   = 0;
        hold  = 0;
        style = 0;
        long_hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 200 == 0) style = $urandom_range(0, 2);
            if (!long_hold_done && cyc > 400 && in_ch.valid) begin
                hold = 300;
                long_hold_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                case (style)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offers one word and returns right after the edge that accepted it.
    // Words go out in bursts; between bursts valid usually drops for a random gap.
    // Ready is sampled at the falling edge, where it is settled for the next rise.
    task automatic offer_word(logic [POINT_W-1:0] pt, logic signed [SUM_WIDTH-1:0] r,
                              logic signed [SUM_WIDTH-1:0] ys, logic signed [SUM_WIDTH-1:0] yc,
                              logic signed [SUM_WIDTH-1:0] us, logic signed [SUM_WIDTH-1:0] uc);
        int  gap;
        bit  took;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid            <= 1'b1;
        in_ch.point_index      <= pt;
        in_ch.ref_sine_sum     <= r;
        in_ch.fb_sine_sum      <= ys;
        in_ch.fb_cosine_sum    <= yc;
        in_ch.drive_sine_sum   <= us;
        in_ch.drive_cosine_sum <= uc;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        words_sent++;
    endtask

    // Stops offering and waits until every result word has come back, then lets
    // the pipe run empty so nothing is still in flight.
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // Writes all three enables, plus the unused index to show it is ignored.
    // One write per edge; the write enable stays high across all four writes.
    task automatic set_enables(logic [RATIO_N-1:0] en);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_EN_OPEN;
        i_cfg_data <= en[RAT_GH];
        @(posedge i_clk);
        i_cfg_idx <= CFG_EN_PLANT;
        i_cfg_data <= en[RAT_H];
        @(posedge i_clk);
        i_cfg_idx <= CFG_EN_CLOSED;
        i_cfg_data <= en[RAT_CL];
        @(posedge i_clk);
        i_cfg_idx <= '1;
        i_cfg_data <= ~en[RAT_GH];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One sum drawn from a mix of extremes, small values and full-range noise.
    function automatic logic signed [SUM_WIDTH-1:0] pick_sum();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(SUM_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(SUM_WIDTH-1){1'b1}}};
            2:       return '0;
            3:       return $signed($urandom_range(0, 16)) - 8;
            4:       return $signed($urandom_range(0, 4000)) - 2000;
            5:       return $signed($urandom) >>> $urandom_range(0, 30);
            default: return $urandom;
        endcase
    endfunction

    // A random point, sometimes shaped so a ratio hits its divisor-zero,
    // zero-magnitude or real-axis corner.
    task automatic random_word();
        logic signed [SUM_WIDTH-1:0] r, ys, yc, us, uc;
        r  = pick_sum();
        ys = pick_sum();
        yc = pick_sum();
        us = pick_sum();
        uc = pick_sum();
        case ($urandom_range(0, 11))
            0: begin ys = r; yc = '0; end
            1: begin us = '0; uc = '0; end
            2: r = '0;
            3: begin ys = '0; yc = '0; end
            4: yc = '0;
            5: uc = '0;
            default: ;
        endcase
        offer_word(POINT_W'($urandom), r, ys, yc, us, uc);
    endtask

    localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    initial begin
        logic [RATIO_N-1:0] phases [8] = '{3'b000, 3'b101, 3'b010, 3'b111,
                                           3'b001, 3'b100, 3'b011, 3'b110};
        words_sent = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.point_index <= '0;
        in_ch.ref_sine_sum <= '0;
        in_ch.fb_sine_sum <= '0;
        in_ch.fb_cosine_sum <= '0;
        in_ch.drive_sine_sum <= '0;
        in_ch.drive_cosine_sum <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points with the reset enables (all three ratios on).
        offer_word(8'd0, '0, '0, '0, '0, '0);                // every divisor zero
        offer_word(8'd255, SMAX, SMAX, SMAX, SMAX, SMAX);
        offer_word(8'd1, SMIN, SMIN, SMIN, SMIN, SMIN);
        offer_word(8'd2, SMIN, SMAX, SMIN, SMAX, SMIN);
        offer_word(8'd3, SMAX, SMIN, SMAX, SMIN, SMAX);
        offer_word(8'd4, 32'sd1, -32'sd1, 32'sd0, 32'sd1, 32'sd0);  // closed loop on negative real axis
        offer_word(8'd5, 32'sd1, 32'sd0, 32'sd0, 32'sd3, 32'sd4);   // closed loop zero magnitude
        offer_word(8'd6, 32'sd77, 32'sd77, 32'sd0, 32'sd0, 32'sd0); // open loop and plant divisor zero
        offer_word(8'd7, 32'sd0, 32'sd5, -32'sd9, 32'sd2, -32'sd2); // closed loop divisor zero
        offer_word(8'd8, 32'sd1000, 32'sd1000, 32'sd1000, 32'sd1000, 32'sd1000);
        offer_word(8'd9, -32'sd1, 32'sd1, -32'sd1, -32'sd1, 32'sd1);
        offer_word(8'd10, SMAX, SMIN, 32'sd0, SMIN, 32'sd0);
        offer_word(8'd11, 32'sd1, SMAX, SMAX, 32'sd1, SMIN);
        offer_word(8'd12, -32'sd3, 32'sd0, 32'sd3, 32'sd0, -32'sd5); // plant on negative real axis
        offer_word(8'd13, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        offer_word(8'd170, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
        repeat (44) random_word();

        // Each enable setting gets its own stretch of random points, written
        // only once the pipe has fully drained.
        foreach (phases[p]) begin
            drain_pipe();
            set_enables(phases[p]);
            repeat (55) random_word();
        end

        drain_pipe();
        $display("Sent %0d input words over nine enable settings; %0d results compared.",
                 words_sent, checked);
        $display("Corners covered: zero divisors, zero magnitude, -180 degree, extreme sums.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[loop_gain_phase_calculator_core.f]
rtl/lgpc_pkg.sv
rtl/lgpc_if.sv
rtl/lgpc_front.sv
rtl/lgpc_ratio.sv
rtl/loop_gain_phase_calculator_core.sv
dv/loop_gain_phase_checker.sv
dv/loop_gain_phase_calculator_core_tb.sv
